### sv/wfce_pkg.sv
// package for the word frame crc encoder
// holds the queue entry type, the sequencer step type and the crc byte update
// no dependencies
package wfce_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam int unsigned FifoDepth = 2;

  typedef struct packed {
    logic [15:0] data_word;
    logic        first;
    logic        last;
  } wfce_entry_t;

  typedef enum logic [2:0] {
    ST_B0,
    ST_B1,
    ST_Z0,
    ST_Z1,
    ST_C1
  } wfce_step_e;

  // shifts one byte into the crc, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      top = r[15];
      r   = {r[14:0], b[i]};
      if (top) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

endpackage

### sv/wfce_front.sv
// front end of the word frame crc encoder: takes words, marks the first of each frame
// depends on wfce_pkg
module wfce_front import wfce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [15:0] data_word_i,
  input  logic        last_word_i,
  input  logic        fifo_full_i,
  output logic        full_o,
  output logic        wr_en_o,
  output wfce_entry_t wr_data_o
);

  logic first_pending_q, first_pending_d;

  assign full_o  = fifo_full_i;
  assign wr_en_o = push_i && !fifo_full_i;

  always_comb begin
    wr_data_o.data_word = data_word_i;
    wr_data_o.first     = first_pending_q;
    wr_data_o.last      = last_word_i;
    first_pending_d     = first_pending_q;
    // a new frame opens after each last word
    if (wr_en_o) begin
      first_pending_d = last_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
    end else begin
      first_pending_q <= first_pending_d;
    end
  end

endmodule

### sv/wfce_fifo.sv
// small queue between front and back of the word frame crc encoder
// depends on wfce_pkg
module wfce_fifo import wfce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  wfce_entry_t wr_data_i,
  output logic        full_o,
  input  logic        rd_en_i,
  output logic        rd_vld_o,
  output wfce_entry_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  wfce_entry_t         mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == CntW'(FifoDepth));
  assign rd_vld_o  = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && rd_vld_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### sv/wfce_back.sv
// back end of the word frame crc encoder: byte sequencer, crc register, output register
// depends on wfce_pkg
module wfce_back import wfce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fifo_vld_i,
  input  wfce_entry_t fifo_data_i,
  output logic        fifo_rd_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  wfce_step_e   step_q, step_d;
  logic         busy_q, busy_d;
  wfce_entry_t  cur_q, cur_d;
  logic [15:0]  crc_q, crc_d;
  logic         out_vld_q, out_vld_d;
  logic [7:0]   out_byte_q, out_byte_d;
  logic         out_end_q, out_end_d;

  logic         out_rdy, emit, adv, at_end, take;
  logic [7:0]   hi_byte, lo_byte, emit_byte;
  logic [15:0]  crc_zero;

  assign hi_byte  = cur_q.data_word[15:8];
  assign lo_byte  = cur_q.data_word[7:0];
  assign crc_zero = crc_byte(crc_q, 8'h00);
  assign out_rdy  = !out_vld_q || pop_i;

  always_comb begin
    step_d     = step_q;
    busy_d     = busy_q;
    cur_d      = cur_q;
    crc_d      = crc_q;
    out_vld_d  = out_vld_q && !pop_i;
    out_byte_d = out_byte_q;
    out_end_d  = out_end_q;
    emit       = 1'b0;
    emit_byte  = lo_byte;
    at_end     = 1'b0;

    case (step_q)
      ST_B0: begin
        emit      = 1'b1;
        emit_byte = cur_q.first ? hi_byte : lo_byte;
      end
      ST_B1: begin
        emit      = 1'b1;
        emit_byte = cur_q.first ? lo_byte : hi_byte;
        at_end    = !cur_q.last;
      end
      ST_Z0: begin
        emit = 1'b0;
      end
      ST_Z1: begin
        emit      = 1'b1;
        emit_byte = crc_zero[7:0];
      end
      ST_C1: begin
        emit      = 1'b1;
        emit_byte = crc_q[15:8];
        at_end    = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    adv = busy_q && (!emit || out_rdy);

    if (adv) begin
      if (emit) begin
        out_vld_d  = 1'b1;
        out_byte_d = emit_byte;
        out_end_d  = (step_q == ST_C1);
      end
      // crc always takes the high byte first, whatever the send order
      case (step_q)
        ST_B0: begin
          crc_d  = crc_byte(crc_q, hi_byte);
          step_d = ST_B1;
        end
        ST_B1: begin
          crc_d  = crc_byte(crc_q, lo_byte);
          step_d = ST_Z0;
        end
        ST_Z0: begin
          crc_d  = crc_zero;
          step_d = ST_Z1;
        end
        ST_Z1: begin
          crc_d  = crc_zero;
          step_d = ST_C1;
        end
        ST_C1: begin
          crc_d  = '0;
          step_d = ST_B0;
        end
        default: begin
          step_d = ST_B0;
        end
      endcase
      if (at_end) begin
        busy_d = 1'b0;
      end
    end

    take = fifo_vld_i && (!busy_q || (adv && at_end));
    if (take) begin
      busy_d = 1'b1;
      cur_d  = fifo_data_i;
      step_d = ST_B0;
    end
  end

  assign fifo_rd_o   = take;
  assign empty_o     = !out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_B0;
      busy_q    <= 1'b0;
      crc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      busy_q    <= busy_d;
      crc_q     <= crc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

endmodule

### sv/word_frame_crc_encoder_unit.sv
// top level of the word frame crc encoder: front, two-entry queue, back
// depends on wfce_pkg, wfce_front, wfce_fifo, wfce_back
//
//   channel   handshake       payload
//   words in  push / full     data_word_i[15:0], last_word_i
//   bytes out empty / pop     out_byte_o[7:0], frame_end_o
//
// a word yields two bytes, a last word four bytes
// (the back sequencer adds step ST_Z0, which sends no byte, for the first half of the zero-word crc pass)
// words enter the queue through the front end; the queue holds two words ahead of the back end
// rst_ni clears the queue, the sequencer and the crc, and sets the first-word flag
// a stalled pop holds the output byte and the sequencer at its next byte step; push keeps going until the queue fills
module word_frame_crc_encoder_unit import wfce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] data_word_i,
  input  logic        last_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  logic        fifo_full, wr_en, rd_en, rd_vld;
  wfce_entry_t wr_data, rd_data;

  wfce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_word_i (data_word_i),
    .last_word_i (last_word_i),
    .fifo_full_i (fifo_full),
    .full_o      (full),
    .wr_en_o     (wr_en),
    .wr_data_o   (wr_data)
  );

  wfce_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .full_o    (fifo_full),
    .rd_en_i   (rd_en),
    .rd_vld_o  (rd_vld),
    .rd_data_o (rd_data)
  );

  wfce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_vld_i  (rd_vld),
    .fifo_data_i (rd_data),
    .fifo_rd_o   (rd_en),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule
